/* hw/rtl/snc_pkg.sv */
// shared types, command codes and constant tables of the serial node responder
package snc_pkg;

   // controller states
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // input beat accepted
      logic advance;  // response beat taken
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_read;  // current input beat opens a response
      logic at_end;      // checksum beat is on the output
   } dp_status_type;

   localparam logic [7:0] READ_LIMIT = 8'h50;

   // read codes
   localparam logic [7:0] RD_API      = 8'h00;
   localparam logic [7:0] RD_FREQ     = 8'h03;
   localparam logic [7:0] RD_LAPSTAT  = 8'h0D;
   localparam logic [7:0] RD_FILTER   = 8'h0E;
   localparam logic [7:0] RD_NODE_ID  = 8'h11;
   localparam logic [7:0] RD_ENTER_AT = 8'h22;
   localparam logic [7:0] RD_RSSI_PK  = 8'h23;
   localparam logic [7:0] RD_ADC      = 8'h24;
   localparam logic [7:0] RD_THR_A    = 8'h31;
   localparam logic [7:0] RD_THR_B    = 8'h32;
   localparam logic [7:0] RD_TIME     = 8'h33;
   localparam logic [7:0] RD_MULTI    = 8'h39;
   localparam logic [7:0] RD_MODE_A   = 8'h3A;
   localparam logic [7:0] RD_MODE_B   = 8'h3C;
   localparam logic [7:0] RD_VERSION  = 8'h3D;
   localparam logic [7:0] RD_DATE     = 8'h3E;
   localparam logic [7:0] RD_CLOCK    = 8'h3F;
   localparam logic [7:0] RD_PROC     = 8'h40;

   // write codes
   localparam logic [7:0] WR_FREQ     = 8'h51;
   localparam logic [7:0] WR_ENTER    = 8'h71;
   localparam logic [7:0] WR_EXIT     = 8'h72;
   localparam logic [7:0] WR_MODE     = 8'h75;
   localparam logic [7:0] WR_CAL      = 8'h78;
   localparam logic [7:0] WR_IGNORED  = 8'h7A;

   // flag bits
   localparam logic [6:0] FLG_ACT   = 7'h01;
   localparam logic [6:0] FLG_SER   = 7'h02;
   localparam logic [6:0] FLG_FSET  = 7'h04;
   localparam logic [6:0] FLG_FCHG  = 7'h08;
   localparam logic [6:0] FLG_ENTER = 7'h10;
   localparam logic [6:0] FLG_EXIT  = 7'h20;
   localparam logic [6:0] FLG_LAPRD = 7'h40;

   localparam logic [15:0] FREQ_RESET = 16'd5800;
   localparam logic [7:0]  THR_RESET  = 8'd96;

   // number of data beats of a read, zero when unknown
   function automatic logic [4:0] read_len(input logic [7:0] code);
      logic [4:0] n;
      case (code)
         RD_API, RD_RSSI_PK, RD_ADC, RD_THR_A, RD_THR_B,
         RD_MULTI, RD_MODE_A, RD_MODE_B: n = 5'd1;
         RD_FREQ, RD_NODE_ID, RD_ENTER_AT: n = 5'd2;
         RD_TIME: n = 5'd4;
         RD_FILTER, RD_LAPSTAT: n = 5'd8;
         RD_CLOCK, RD_PROC: n = 5'd9;
         RD_DATE: n = 5'd12;
         RD_VERSION: n = 5'd17;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

   // payload bytes of a write, zero when none
   function automatic logic [1:0] write_len(input logic [7:0] code);
      logic [1:0] n;
      case (code)
         WR_FREQ, WR_MODE: n = 2'd2;
         WR_ENTER, WR_EXIT, WR_CAL, WR_IGNORED: n = 2'd1;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   // fixed strings, length byte first
   function automatic logic [7:0] rom_byte(input logic [7:0] code, input logic [4:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (code)
         RD_VERSION: begin
            case (idx)
               5'd0: b = 8'd16;
               5'd1: b = 8'h45; 5'd2: b = 8'h53; 5'd3: b = 8'h50; 5'd4: b = 8'h33;
               5'd5: b = 8'h32; 5'd6: b = 8'h5F; 5'd7: b = 8'h4C; 5'd8: b = 8'h69;
               5'd9: b = 8'h74; 5'd10: b = 8'h65; 5'd11: b = 8'h5F; 5'd12: b = 8'h31;
               5'd13: b = 8'h2E; 5'd14: b = 8'h30; 5'd15: b = 8'h2E; 5'd16: b = 8'h30;
               default: b = 8'h00;
            endcase
         end
         RD_DATE: begin
            case (idx)
               5'd0: b = 8'd11;
               5'd1: b = 8'h4A; 5'd2: b = 8'h61; 5'd3: b = 8'h6E; 5'd4: b = 8'h20;
               5'd5: b = 8'h20; 5'd6: b = 8'h31; 5'd7: b = 8'h20; 5'd8: b = 8'h32;
               5'd9: b = 8'h30; 5'd10: b = 8'h32; 5'd11: b = 8'h34;
               default: b = 8'h00;
            endcase
         end
         RD_CLOCK: begin
            case (idx)
               5'd0: b = 8'd8;
               5'd1: b = 8'h30; 5'd2: b = 8'h30; 5'd3: b = 8'h3A; 5'd4: b = 8'h30;
               5'd5: b = 8'h30; 5'd6: b = 8'h3A; 5'd7: b = 8'h30; 5'd8: b = 8'h30;
               default: b = 8'h00;
            endcase
         end
         RD_PROC: begin
            case (idx)
               5'd0: b = 8'd8;
               5'd1: b = 8'h45; 5'd2: b = 8'h53; 5'd3: b = 8'h50; 5'd4: b = 8'h33;
               5'd5: b = 8'h32; 5'd6: b = 8'h2D; 5'd7: b = 8'h43; 5'd8: b = 8'h33;
               default: b = 8'h00;
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* hw/rtl/snc_ctrl.sv */
// controller state machine: input acceptance and response sequencing
module snc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  snc_pkg::dp_status_type status,
   output snc_pkg::dp_cmd_type    cmd
);

   snc_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= snc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      case (state_ff)
         snc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            if (req_valid && status.start_read) begin
               state_in = snc_pkg::ST_EMIT;
            end
         end
         snc_pkg::ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = !rsp_stall;
            if (!rsp_stall && status.at_end) begin
               state_in = snc_pkg::ST_IDLE;
            end
         end
         default: state_in = snc_pkg::ST_IDLE;
      endcase
   end

endmodule

/* hw/rtl/snc_dp.sv */
// datapath: node state, payload collection and response byte generation
module snc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  snc_pkg::dp_cmd_type    cmd,
   output snc_pkg::dp_status_type status,
   input  logic                   req_cmd,
   input  logic [7:0]             req_rx_byte,
   input  logic [31:0]            req_now_ms,
   input  logic [7:0]             req_rssi_now,
   input  logic [7:0]             req_rssi_max,
   input  logic [31:0]            req_lap_time_ms,
   input  logic [7:0]             req_lap_rssi_max,
   output logic [7:0]             rsp_tx_byte,
   output logic                   rsp_last_byte,
   output logic [6:0]             rsp_activity_flags
);

   logic [7:0]  code_ff, code_in;
   logic [4:0]  idx_ff, idx_in;
   logic [7:0]  sum_ff, sum_in;
   logic [31:0] now_ff;
   logic [7:0]  rnow_ff, rpeak_ff;
   logic [15:0] freq_ff, freq_in;
   logic [7:0]  thr_ff, thr_in;
   logic [6:0]  flags_ff, flags_in;
   logic [7:0]  lap_cnt_ff;
   logic [31:0] lap_ts_ff;
   logic [7:0]  lap_pk_ff;
   logic [7:0]  pend_ff, pend_in;
   logic [1:0]  pexp_ff, pexp_in;
   logic [1:0]  pcnt_ff, pcnt_in;
   logic [7:0]  pbytes_ff [3];

   logic        idle_byte, is_read;
   logic [4:0]  rlen_now, rlen;
   logic [1:0]  wlen, pcnt_next;
   logic [7:0]  psum;
   logic [15:0] delta;
   logic [7:0]  data_byte;

   assign idle_byte = !req_cmd && (pexp_ff == 2'd0);
   assign is_read   = idle_byte && (req_rx_byte <= snc_pkg::READ_LIMIT);
   assign rlen_now  = snc_pkg::read_len(req_rx_byte);
   assign wlen      = snc_pkg::write_len(req_rx_byte);
   assign rlen      = snc_pkg::read_len(code_ff);
   assign pcnt_next = pcnt_ff + 2'd1;
   assign psum      = (pexp_ff == 2'd3) ? (pbytes_ff[0] + pbytes_ff[1]) : pbytes_ff[0];
   assign delta     = now_ff[15:0] - lap_ts_ff[15:0];

   assign status.start_read = is_read && (rlen_now != 5'd0);
   assign status.at_end     = (idx_ff == rlen);

   // data byte of the current response beat
   always_comb begin
      data_byte = 8'h00;
      case (code_ff)
         snc_pkg::RD_API: data_byte = 8'h08;
         snc_pkg::RD_FREQ: data_byte = (idx_ff == 5'd0) ? freq_ff[15:8] : freq_ff[7:0];
         snc_pkg::RD_LAPSTAT: begin
            case (idx_ff)
               5'd0: data_byte = lap_cnt_ff;
               5'd1: data_byte = delta[15:8];
               5'd2: data_byte = delta[7:0];
               5'd3: data_byte = rnow_ff;
               5'd4: data_byte = rpeak_ff;
               5'd5: data_byte = lap_pk_ff;
               5'd6: data_byte = 8'h03;
               5'd7: data_byte = 8'hE8;
               default: data_byte = 8'h00;
            endcase
         end
         snc_pkg::RD_FILTER:
            data_byte = (idx_ff == 5'd1 || idx_ff == 5'd2) ? 8'd30 : 8'h00;
         snc_pkg::RD_ENTER_AT: data_byte = (idx_ff == 5'd0) ? 8'h25 : 8'd35;
         snc_pkg::RD_RSSI_PK: data_byte = rpeak_ff;
         snc_pkg::RD_ADC: data_byte = 8'd30;
         snc_pkg::RD_THR_A, snc_pkg::RD_THR_B: data_byte = thr_ff;
         snc_pkg::RD_TIME: begin
            case (idx_ff[1:0])
               2'd0: data_byte = now_ff[31:24];
               2'd1: data_byte = now_ff[23:16];
               2'd2: data_byte = now_ff[15:8];
               default: data_byte = now_ff[7:0];
            endcase
         end
         snc_pkg::RD_MULTI: data_byte = 8'h01;
         snc_pkg::RD_VERSION, snc_pkg::RD_DATE, snc_pkg::RD_CLOCK, snc_pkg::RD_PROC:
            data_byte = snc_pkg::rom_byte(code_ff, idx_ff);
         default: data_byte = 8'h00;
      endcase
   end

   assign rsp_tx_byte        = status.at_end ? sum_ff : data_byte;
   assign rsp_last_byte      = status.at_end;
   assign rsp_activity_flags = flags_ff;

   // next state of the node registers
   always_comb begin
      code_in  = code_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      freq_in  = freq_ff;
      thr_in   = thr_ff;
      flags_in = flags_ff;
      pend_in  = pend_ff;
      pexp_in  = pexp_ff;
      pcnt_in  = pcnt_ff;
      if (cmd.advance) begin
         idx_in = idx_ff + 5'd1;
         sum_in = sum_ff + data_byte;
      end
      if (cmd.load && !req_cmd) begin
         if (pexp_ff == 2'd0) begin
            pend_in = req_rx_byte;
            if (is_read) begin
               code_in = req_rx_byte;
               idx_in  = 5'd0;
               sum_in  = 8'h00;
               if (rlen_now != 5'd0) begin
                  flags_in = flags_in | snc_pkg::FLG_ACT | snc_pkg::FLG_SER;
               end
               if (req_rx_byte == snc_pkg::RD_LAPSTAT) begin
                  flags_in = flags_in | snc_pkg::FLG_LAPRD;
               end
            end else if (wlen != 2'd0) begin
               pcnt_in = 2'd0;
               pexp_in = wlen + 2'd1;
            end
         end else begin
            pcnt_in = pcnt_next;
            if (pcnt_next == pexp_ff) begin
               pexp_in = 2'd0;
               pcnt_in = 2'd0;
               // checksum byte is the current beat
               if (req_rx_byte == psum) begin
                  case (pend_ff)
                     snc_pkg::WR_FREQ: begin
                        freq_in  = {pbytes_ff[0], pbytes_ff[1]};
                        flags_in = flags_ff | snc_pkg::FLG_FSET | snc_pkg::FLG_FCHG
                                 | snc_pkg::FLG_ACT | snc_pkg::FLG_SER;
                     end
                     snc_pkg::WR_ENTER: begin
                        thr_in   = pbytes_ff[0];
                        flags_in = flags_ff | snc_pkg::FLG_ENTER
                                 | snc_pkg::FLG_ACT | snc_pkg::FLG_SER;
                     end
                     snc_pkg::WR_EXIT: begin
                        thr_in   = pbytes_ff[0];
                        flags_in = flags_ff | snc_pkg::FLG_EXIT
                                 | snc_pkg::FLG_ACT | snc_pkg::FLG_SER;
                     end
                     snc_pkg::WR_MODE, snc_pkg::WR_CAL:
                        flags_in = flags_ff | snc_pkg::FLG_ACT | snc_pkg::FLG_SER;
                     default: flags_in = flags_ff;
                  endcase
                  pend_in = 8'h00;
               end
            end
         end
      end
   end

   // control and node registers
   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff    <= 8'h00;
         idx_ff     <= 5'd0;
         sum_ff     <= 8'h00;
         freq_ff    <= snc_pkg::FREQ_RESET;
         thr_ff     <= snc_pkg::THR_RESET;
         flags_ff   <= 7'h00;
         lap_cnt_ff <= 8'h00;
         lap_ts_ff  <= 32'h0;
         lap_pk_ff  <= 8'h00;
         pend_ff    <= 8'h00;
         pexp_ff    <= 2'd0;
         pcnt_ff    <= 2'd0;
      end else begin
         code_ff  <= code_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
         freq_ff  <= freq_in;
         thr_ff   <= thr_in;
         flags_ff <= flags_in;
         pend_ff  <= pend_in;
         pexp_ff  <= pexp_in;
         pcnt_ff  <= pcnt_in;
         // lap event
         if (cmd.load && req_cmd) begin
            lap_ts_ff  <= req_lap_time_ms;
            lap_pk_ff  <= req_lap_rssi_max;
            lap_cnt_ff <= lap_cnt_ff + 8'd1;
         end
      end
   end

   // read snapshot and payload bytes
   always_ff @(posedge clock) begin
      if (cmd.load && is_read) begin
         now_ff   <= req_now_ms;
         rnow_ff  <= req_rssi_now;
         rpeak_ff <= req_rssi_max;
      end
      if (cmd.load && !req_cmd && pexp_ff != 2'd0 && pcnt_ff != 2'd3) begin
         pbytes_ff[pcnt_ff] <= req_rx_byte;
      end
   end

endmodule

/* hw/rtl/serial_node_command_responder.sv */
// top level of the serial node command responder
//
// input channel (req_): one beat is either a received serial byte (req_cmd = 0)
// or a lap event (req_cmd = 1) with its timestamp and peak strength.
// result channel (rsp_): one beat per response byte, big-endian fields, the
// 8-bit sum checksum last with rsp_last_byte set; rsp_activity_flags carries
// the accumulated flag bits after the command.
// a read byte that is known opens a response of 2 to 18 beats; the byte is
// taken and the first response beat shows the next cycle, one beat per cycle
// after that while the receiver does not stall.
// an item that causes no response (lap event, write byte, unknown read)
// leaves the block idle, so such items pass at one per cycle.
// while a response is out, req_stall stays high; the response sequencer
// holds one item at a time. a stalled response beat holds its value.
// reset clears all control state, restores frequency 5800 and threshold 96,
// and leaves the block idle, ready for an input beat the next cycle.
module serial_node_command_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_rx_byte,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_rssi_now,
   input  logic [7:0]  req_rssi_max,
   input  logic [31:0] req_lap_time_ms,
   input  logic [7:0]  req_lap_rssi_max,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_byte,
   output logic [6:0]  rsp_activity_flags
);

   snc_pkg::dp_cmd_type    dp_cmd;
   snc_pkg::dp_status_type dp_status;

   // sequencer
   snc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // node state and byte generation
   snc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .status             (dp_status),
      .req_cmd            (req_cmd),
      .req_rx_byte        (req_rx_byte),
      .req_now_ms         (req_now_ms),
      .req_rssi_now       (req_rssi_now),
      .req_rssi_max       (req_rssi_max),
      .req_lap_time_ms    (req_lap_time_ms),
      .req_lap_rssi_max   (req_lap_rssi_max),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_activity_flags (rsp_activity_flags)
   );

   // no input beat while a response is out
   a_stall_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during response");

   // response ends after the checksum beat
   a_end_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_byte && !rsp_stall) |=> !rsp_valid)
      else $error("response continues after last beat");

   // flags never change during a response
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid)) |-> $stable(rsp_activity_flags))
      else $error("flags changed during response");

   // idle after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule
